>>> sv/psd_pkg.sv
`default_nettype none
package psd_pkg;

  localparam int COORD_W = 24;
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W = PROD_W + 1;
  localparam int SQ_W = PROD_W - 1;
  localparam int CLO_W = 25;
  localparam int CHI_W = SQ_W - CLO_W;
  localparam int DIVD_W = 2 * SQ_W;
  localparam int QUO_W = 50;
  localparam int DIST_W = 25;
  localparam int SQRT_RW = DIST_W + 3;
  localparam int IN_DATA_W = 6 * COORD_W;
  localparam int OUT_DATA_W = 32;
  localparam int CASE_W = 2;
  localparam int FRONT_N = 6;
  localparam logic [DIST_W-1:0] DIST_MAX = 25'd23726565;

  typedef enum logic [CASE_W-1:0] {
    CASE_DEGEN    = 2'd0,
    CASE_BEFORE   = 2'd1,
    CASE_BEYOND   = 2'd2,
    CASE_INTERIOR = 2'd3
  } case_e;

endpackage
`default_nettype wire

>>> sv/point_segment_distance_core.sv
// Channel  | Direction | tdata (low bit up)                                 | tuser
// s_axis   | in        | start_x, start_y, end_x, end_y, query_x, query_y   | -
// m_axis   | out       | distance, zero fill to 32 bits                     | nearest_case
//
// One request enters per cycle unless a stalled output has filled the stages behind it.
// Each request passes through the front stages, the 50-stage restoring divider and the 25-stage square root.
// Reset clears only the valid bits of the stages.
// Stages hold while the output is stalled, and a free stage ahead of them still fills.
`default_nettype none
module point_segment_distance_core (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // start_x, start_y, end_x, end_y, query_x, query_y
  input  wire  [psd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // distance, zero fill
  output logic [psd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // nearest_case
  output logic [psd_pkg::CASE_W-1:0]         m_axis_tuser
);

  localparam int CW = psd_pkg::COORD_W;
  localparam int DW = psd_pkg::DIFF_W;
  localparam int PW = psd_pkg::PROD_W;
  localparam int SW = psd_pkg::SUM_W;
  localparam int QW = psd_pkg::SQ_W;
  localparam int LW = psd_pkg::CLO_W;
  localparam int HW = psd_pkg::CHI_W;
  localparam int FN = psd_pkg::FRONT_N;

  logic [FN-1:0] v_q;
  logic [FN-1:0] en;
  logic          div_in_ready;

  logic signed [DW-1:0] s1_dx_q, s1_dy_q, s1_vx_q, s1_vy_q, s1_wx_q, s1_wy_q;
  logic signed [PW-1:0] s2_dxx_q, s2_dyy_q, s2_vxdx_q, s2_vydy_q, s2_vxdy_q, s2_vydx_q;
  logic signed [PW-1:0] s2_vxx_q, s2_vyy_q, s2_wxx_q, s2_wyy_q;
  logic [QW-1:0]        s3_len2_q, s3_vsq_q, s3_wsq_q;
  logic signed [SW-1:0] s3_dot_q, s3_cross_q;
  logic [QW-1:0]        s4_len2_q, s4_esq_q, s4_cmag_q;
  psd_pkg::case_e       s4_case_q, s5_case_q, s6_case_q;
  logic [QW-1:0]        s5_len2_q, s5_esq_q;
  logic [2*LW-1:0]      s5_pll_q;
  logic [LW+HW-1:0]     s5_plh_q;
  logic [2*HW-1:0]      s5_phh_q;
  logic [psd_pkg::DIVD_W-1:0] s6_dvd_q;
  logic [QW-1:0]        s6_dvs_q;

  logic signed [CW-1:0] sx, sy, ex, ey, qx, qy;
  logic [SW-1:0]        len2_sum, vsq_sum, wsq_sum;
  logic signed [SW-1:0] cross_abs;
  psd_pkg::case_e       case_d;
  logic [psd_pkg::DIVD_W-1:0] c2;

  logic                       dq_valid, dq_ready;
  logic [psd_pkg::QUO_W-1:0]  dq_quo;
  psd_pkg::case_e             dq_case;
  logic [psd_pkg::DIST_W-1:0] root;
  psd_pkg::case_e             out_case;

  assign sx = s_axis_tdata[0*CW +: CW];
  assign sy = s_axis_tdata[1*CW +: CW];
  assign ex = s_axis_tdata[2*CW +: CW];
  assign ey = s_axis_tdata[3*CW +: CW];
  assign qx = s_axis_tdata[4*CW +: CW];
  assign qy = s_axis_tdata[5*CW +: CW];

  assign en[FN-1] = ~v_q[FN-1] | div_in_ready;
  for (genvar k = 0; k < FN - 1; k++) begin : g_en
    assign en[k] = ~v_q[k] | en[k+1];
  end
  assign s_axis_tready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < FN; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign len2_sum = {1'b0, s2_dxx_q} + {1'b0, s2_dyy_q};
  assign vsq_sum = {1'b0, s2_vxx_q} + {1'b0, s2_vyy_q};
  assign wsq_sum = {1'b0, s2_wxx_q} + {1'b0, s2_wyy_q};
  assign cross_abs = s3_cross_q[SW-1] ? -s3_cross_q : s3_cross_q;

  always_comb begin
    if (s3_len2_q == '0) begin
      case_d = psd_pkg::CASE_DEGEN;
    end else if (s3_dot_q[SW-1]) begin
      case_d = psd_pkg::CASE_BEFORE;
    end else if (s3_dot_q[SW-2:0] > {1'b0, s3_len2_q}) begin
      case_d = psd_pkg::CASE_BEYOND;
    end else begin
      case_d = psd_pkg::CASE_INTERIOR;
    end
  end

  assign c2 = ({{(psd_pkg::DIVD_W - 2*HW){1'b0}}, s5_phh_q} << (2*LW))
            + ({{(psd_pkg::DIVD_W - LW - HW){1'b0}}, s5_plh_q} << (LW + 1))
            + {{(psd_pkg::DIVD_W - 2*LW){1'b0}}, s5_pll_q};

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_dx_q <= {ex[CW-1], ex} - {sx[CW-1], sx};
      s1_dy_q <= {ey[CW-1], ey} - {sy[CW-1], sy};
      s1_vx_q <= {qx[CW-1], qx} - {sx[CW-1], sx};
      s1_vy_q <= {qy[CW-1], qy} - {sy[CW-1], sy};
      s1_wx_q <= {qx[CW-1], qx} - {ex[CW-1], ex};
      s1_wy_q <= {qy[CW-1], qy} - {ey[CW-1], ey};
    end
    if (en[1]) begin
      s2_dxx_q  <= s1_dx_q * s1_dx_q;
      s2_dyy_q  <= s1_dy_q * s1_dy_q;
      s2_vxdx_q <= s1_vx_q * s1_dx_q;
      s2_vydy_q <= s1_vy_q * s1_dy_q;
      s2_vxdy_q <= s1_vx_q * s1_dy_q;
      s2_vydx_q <= s1_vy_q * s1_dx_q;
      s2_vxx_q  <= s1_vx_q * s1_vx_q;
      s2_vyy_q  <= s1_vy_q * s1_vy_q;
      s2_wxx_q  <= s1_wx_q * s1_wx_q;
      s2_wyy_q  <= s1_wy_q * s1_wy_q;
    end
    if (en[2]) begin
      s3_len2_q  <= len2_sum[QW-1:0];
      s3_vsq_q   <= vsq_sum[QW-1:0];
      s3_wsq_q   <= wsq_sum[QW-1:0];
      s3_dot_q   <= {s2_vxdx_q[PW-1], s2_vxdx_q} + {s2_vydy_q[PW-1], s2_vydy_q};
      s3_cross_q <= {s2_vxdy_q[PW-1], s2_vxdy_q} - {s2_vydx_q[PW-1], s2_vydx_q};
    end
    if (en[3]) begin
      s4_len2_q <= s3_len2_q;
      s4_esq_q  <= (case_d == psd_pkg::CASE_BEYOND) ? s3_wsq_q : s3_vsq_q;
      s4_cmag_q <= cross_abs[QW-1:0];
      s4_case_q <= case_d;
    end
    if (en[4]) begin
      s5_len2_q <= s4_len2_q;
      s5_esq_q  <= s4_esq_q;
      s5_pll_q  <= s4_cmag_q[LW-1:0] * s4_cmag_q[LW-1:0];
      s5_plh_q  <= s4_cmag_q[LW-1:0] * s4_cmag_q[QW-1:LW];
      s5_phh_q  <= s4_cmag_q[QW-1:LW] * s4_cmag_q[QW-1:LW];
      s5_case_q <= s4_case_q;
    end
    if (en[5]) begin
      if (s5_case_q == psd_pkg::CASE_INTERIOR) begin
        s6_dvd_q <= c2;
        s6_dvs_q <= s5_len2_q;
      end else begin
        s6_dvd_q <= {{(psd_pkg::DIVD_W - QW){1'b0}}, s5_esq_q};
        s6_dvs_q <= {{(QW - 1){1'b0}}, 1'b1};
      end
      s6_case_q <= s5_case_q;
    end
  end

  psd_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v_q[FN-1]),
    .in_ready_o  (div_in_ready),
    .dividend_i  (s6_dvd_q),
    .divisor_i   (s6_dvs_q),
    .case_i      (s6_case_q),
    .out_valid_o (dq_valid),
    .out_ready_i (dq_ready),
    .quotient_o  (dq_quo),
    .case_o      (dq_case)
  );

  psd_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dq_valid),
    .in_ready_o  (dq_ready),
    .radicand_i  (dq_quo),
    .case_i      (dq_case),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .root_o      (root),
    .case_o      (out_case)
  );

  assign m_axis_tdata = {{(psd_pkg::OUT_DATA_W - psd_pkg::DIST_W){1'b0}}, root};
  assign m_axis_tuser = out_case;

endmodule
`default_nettype wire

>>> sv/psd_div.sv
`default_nettype none
module psd_div (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  [psd_pkg::DIVD_W-1:0]        dividend_i,
  input  wire  [psd_pkg::SQ_W-1:0]          divisor_i,
  input  psd_pkg::case_e                    case_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [psd_pkg::QUO_W-1:0]         quotient_o,
  output psd_pkg::case_e                    case_o
);

  localparam int N = psd_pkg::QUO_W;
  localparam int RW = psd_pkg::SQ_W;

  logic [N:0]         v_q;
  logic [N:0]         en;
  logic [RW-1:0]      r_q   [0:N];
  logic [N-1:0]       lo_q  [0:N];
  logic [RW-1:0]      dv_q  [0:N];
  logic [N-1:0]       quo_q [0:N];
  psd_pkg::case_e     cs_q  [0:N];

  assign en[N] = ~v_q[N] | out_ready_i;
  assign in_ready_o = en[0];
  assign out_valid_o = v_q[N];
  assign quotient_o = quo_q[N];
  assign case_o = cs_q[N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en[0]) begin
      v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      r_q[0]   <= {{(RW - (psd_pkg::DIVD_W - N)){1'b0}}, dividend_i[psd_pkg::DIVD_W-1:N]};
      lo_q[0]  <= dividend_i[N-1:0];
      dv_q[0]  <= divisor_i;
      quo_q[0] <= '0;
      cs_q[0]  <= case_i;
    end
  end

  for (genvar s = 1; s <= N; s++) begin : g_stage
    logic [RW:0]   trial;
    logic [RW:0]   diff;
    logic          take;

    assign en[s-1] = ~v_q[s-1] | en[s];
    assign trial = {r_q[s-1], lo_q[s-1][N-s]};
    assign diff = trial - {1'b0, dv_q[s-1]};
    assign take = trial >= {1'b0, dv_q[s-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= v_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        r_q[s]   <= take ? diff[RW-1:0] : trial[RW-1:0];
        lo_q[s]  <= lo_q[s-1];
        dv_q[s]  <= dv_q[s-1];
        quo_q[s] <= {quo_q[s-1][N-2:0], take};
        cs_q[s]  <= cs_q[s-1];
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/psd_sqrt.sv
`default_nettype none
module psd_sqrt (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  [psd_pkg::QUO_W-1:0]         radicand_i,
  input  psd_pkg::case_e                    case_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [psd_pkg::DIST_W-1:0]        root_o,
  output psd_pkg::case_e                    case_o
);

  localparam int N = psd_pkg::DIST_W;
  localparam int RW = psd_pkg::SQRT_RW;
  localparam int XW = psd_pkg::QUO_W;

  logic [N:0]         v_q;
  logic [N:0]         en;
  logic [RW-1:0]      r_q  [0:N];
  logic [XW-1:0]      x_q  [0:N];
  logic [N-1:0]       q_q  [0:N];
  psd_pkg::case_e     cs_q [0:N];

  assign en[N] = ~v_q[N] | out_ready_i;
  assign in_ready_o = en[0];
  assign out_valid_o = v_q[N];
  assign root_o = q_q[N];
  assign case_o = cs_q[N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en[0]) begin
      v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      r_q[0]  <= '0;
      x_q[0]  <= radicand_i;
      q_q[0]  <= '0;
      cs_q[0] <= case_i;
    end
  end

  for (genvar s = 1; s <= N; s++) begin : g_stage
    logic [RW-1:0] trial;
    logic [RW-1:0] t;
    logic [RW-1:0] diff;
    logic          take;

    assign en[s-1] = ~v_q[s-1] | en[s];
    assign trial = {r_q[s-1][RW-3:0], x_q[s-1][2*(N-s)+1 -: 2]};
    assign t = {{(RW - N - 2){1'b0}}, q_q[s-1], 2'b01};
    assign diff = trial - t;
    assign take = trial >= t;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= v_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        r_q[s]  <= take ? diff : trial;
        x_q[s]  <= x_q[s-1];
        q_q[s]  <= {q_q[s-1][N-2:0], take};
        cs_q[s] <= cs_q[s-1];
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/psd_checker.sv
`default_nettype none
module psd_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             s_axis_tvalid,
  input wire                             s_axis_tready,
  input wire                             m_axis_tvalid,
  input wire                             m_axis_tready,
  input wire [psd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input wire [psd_pkg::CASE_W-1:0]       m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("Stalled result changed.");

  a_only_output_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("Input blocked while the output is free.");

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[psd_pkg::DIST_W-1:0] <= psd_pkg::DIST_MAX
      && m_axis_tdata[psd_pkg::OUT_DATA_W-1:psd_pkg::DIST_W] == '0)
    else $error("Distance out of range.");

  a_in_ready_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && m_axis_tready |-> s_axis_tready)
    else $error("Request refused with a free output.");

endmodule

bind point_segment_distance_core psd_checker u_psd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
